// ----- sv/nqbe_pkg.sv -----
// ----------------------------------------------------------------------------
// nqbe_pkg
// Shared constants and controller/datapath interface types for the N-queens
// backtracking enumerator.
// ----------------------------------------------------------------------------
package nqbe_pkg;

  localparam int DEFAULT_MAX_N     = 16;
  localparam int RESULT_ROWS_LIMIT = 16;

  localparam int BOARD_SIZE_W = 5;
  localparam int ROW_INDEX_W  = 4;
  localparam int COLUMN_W     = 4;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic [BOARD_SIZE_W-1:0] BOARD_SIZE_RESET = 5'd8;

  // register word index (paddr[2])
  localparam logic [0:0] REG_BOARD_SIZE = 1'b0;

  typedef struct packed {
    logic accept;   // input item taken
    logic step;     // one search step
    logic fail;     // search ran out: empty board, mark exhausted
    logic set_exh;  // mark exhausted
    logic out_sel;  // read port follows output row counter
    logic out_row;  // load one solution row into the output register
    logic out_none; // load the no-solution result
    logic resume;   // continue at the last row's next column
  } cmd_t;

  typedef struct packed {
    logic none_now;
    logic done_found;
    logic done_none;
    logic out_free;
    logic out_last;
  } sts_t;

endpackage

// ----- sv/n_queens_backtrack_enumerator_unit.sv -----
// ----------------------------------------------------------------------------
// n_queens_backtrack_enumerator_unit
// N-queens solution enumerator, depth-first backtracking, one request per
// item; returns the next solution row by row or a single no-solution item.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o  | restart_i
//   out     | output    | out_valid_o / out_stall_i| found_o row_index_o column_o last_o
//   cfg     | APB       | psel/penable/pready      | board_size at 0x0
//
// One search step (place, reject or back up) per cycle; the conflict check
// compares the candidate against all placed rows in parallel.
// A request runs a start state, the search steps, then one result row per cycle unless the output stalls.
// Reset empties the board, board size 8; no clearing pass.
// Output stalls hold the sequencer; the next request is taken while the
// last result of the previous one still waits.
// ----------------------------------------------------------------------------
module n_queens_backtrack_enumerator_unit #(
  parameter int MAX_N = nqbe_pkg::DEFAULT_MAX_N
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic [nqbe_pkg::ROW_INDEX_W-1:0]    row_index_o,
  output logic [nqbe_pkg::COLUMN_W-1:0]       column_o,
  output logic                                last_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nqbe_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [nqbe_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [nqbe_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  nqbe_pkg::cmd_t                    cmd;
  nqbe_pkg::sts_t                    sts;
  logic                              reg_hit;
  logic                              cfg_we;
  logic [nqbe_pkg::BOARD_SIZE_W-1:0] board_size;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2:2] == nqbe_pkg::REG_BOARD_SIZE);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? nqbe_pkg::APB_DATA_W'(board_size) : '0;

  nqbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nqbe_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .restart_i    (restart_i),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (pwdata[nqbe_pkg::BOARD_SIZE_W-1:0]),
    .board_size_o (board_size),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .found_o      (found_o),
    .row_index_o  (row_index_o),
    .column_o     (column_o),
    .last_o       (last_o)
  );

endmodule

// ----- sv/nqbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// nqbe_ctrl
// Sequencer: takes a request, runs the search one step per cycle, then walks
// the result rows, or the no-solution item, out through the datapath's output register.
// ----------------------------------------------------------------------------
module nqbe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  nqbe_pkg::sts_t    sts_i,
  output nqbe_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SOLN   = 3'd3;
  localparam logic [2:0] S_NONE   = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_START;
        end
      end
      S_START: begin
        state_d = sts_i.none_now ? S_NONE : S_SEARCH;
      end
      S_SEARCH: begin
        if (sts_i.done_found) begin
          state_d = S_SOLN;
        end else if (sts_i.done_none) begin
          cmd_o.fail = 1'b1;
          state_d    = S_NONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_SOLN: begin
        cmd_o.out_sel = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.out_row = 1'b1;
          if (sts_i.out_last) begin
            cmd_o.resume = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      S_NONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_none = 1'b1;
          cmd_o.set_exh  = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/nqbe_datapath.sv -----
// ----------------------------------------------------------------------------
// nqbe_datapath
// Board state, parallel conflict check against placed rows, search step
// update, board size register and the output register.
// ----------------------------------------------------------------------------
module nqbe_datapath #(
  parameter int MAX_N = nqbe_pkg::DEFAULT_MAX_N
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  nqbe_pkg::cmd_t                       cmd_i,
  output nqbe_pkg::sts_t                       sts_o,
  input  logic                                 restart_i,
  input  logic                                 cfg_we_i,
  input  logic [nqbe_pkg::BOARD_SIZE_W-1:0]    cfg_data_i,
  output logic [nqbe_pkg::BOARD_SIZE_W-1:0]    board_size_o,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic                                 found_o,
  output logic [nqbe_pkg::ROW_INDEX_W-1:0]     row_index_o,
  output logic [nqbe_pkg::COLUMN_W-1:0]        column_o,
  output logic                                 last_o
);

  localparam int ROWS  = (MAX_N < nqbe_pkg::RESULT_ROWS_LIMIT) ? MAX_N
                                                               : nqbe_pkg::RESULT_ROWS_LIMIT;
  localparam int CNT_W = $clog2(ROWS + 1);
  localparam int IDX_W = $clog2(ROWS);

  logic [nqbe_pkg::BOARD_SIZE_W-1:0] board_size_q, board_size_d;
  logic [CNT_W-1:0]                  row_q, row_d;
  logic [CNT_W-1:0]                  col_q, col_d;
  logic                              exh_q, exh_d;
  logic [IDX_W-1:0]                  out_idx_q, out_idx_d;
  logic [IDX_W-1:0]                  placed_q [ROWS];

  logic                              out_valid_q, out_valid_d;
  logic                              found_q;
  logic [nqbe_pkg::ROW_INDEX_W-1:0]  row_index_q;
  logic [nqbe_pkg::COLUMN_W-1:0]     column_q;
  logic                              last_q;

  logic [CNT_W-1:0] n;
  logic [IDX_W-1:0] col_idx;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_data;
  logic [ROWS-1:0]  lane_hit;
  logic             unsafe;
  logic             row_done;
  logic             col_over;
  logic             out_free;
  logic             out_last;
  logic             place;

  // effective board size: 0 acts as 1, saturate at ROWS
  always_comb begin
    if (board_size_q == '0) begin
      n = CNT_W'(1);
    end else if (32'(board_size_q) > 32'(ROWS)) begin
      n = CNT_W'(ROWS);
    end else begin
      n = CNT_W'(board_size_q);
    end
  end

  assign col_idx  = col_q[IDX_W-1:0];
  assign row_done = (row_q >= n);
  assign col_over = (col_q >= n);

  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    logic [IDX_W-1:0] pc;
    logic [IDX_W-1:0] diff;
    logic [CNT_W-1:0] gap;
    assign pc          = placed_q[r];
    assign diff        = (pc > col_idx) ? (pc - col_idx) : (col_idx - pc);
    assign gap         = row_q - CNT_W'(r);
    assign lane_hit[r] = (CNT_W'(r) < row_q) &&
                         ((diff == '0) || (CNT_W'(diff) == gap));
  end

  assign unsafe = |lane_hit;
  assign place  = cmd_i.step && !col_over && !unsafe;

  assign rd_addr = cmd_i.out_sel ? out_idx_q : IDX_W'(row_q - CNT_W'(1));
  assign rd_data = placed_q[rd_addr];

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_last = (out_idx_q == IDX_W'(n - CNT_W'(1)));

  assign sts_o.none_now   = exh_q || (row_q > n);
  assign sts_o.done_found = row_done;
  assign sts_o.done_none  = !row_done && col_over && (row_q == '0);
  assign sts_o.out_free   = out_free;
  assign sts_o.out_last   = out_last;

  always_comb begin
    board_size_d = board_size_q;
    row_d        = row_q;
    col_d        = col_q;
    exh_d        = exh_q;
    out_idx_d    = out_idx_q;
    if (cfg_we_i) begin
      board_size_d = cfg_data_i;
      row_d        = '0;
      col_d        = '0;
      exh_d        = 1'b0;
    end else if (cmd_i.accept) begin
      out_idx_d = '0;
      if (restart_i) begin
        row_d = '0;
        col_d = '0;
        exh_d = 1'b0;
      end
    end else if (cmd_i.fail) begin
      row_d = '0;
      col_d = '0;
      exh_d = 1'b1;
    end else if (cmd_i.set_exh) begin
      exh_d = 1'b1;
    end else if (cmd_i.step) begin
      if (col_over) begin
        // back up one row
        row_d = row_q - CNT_W'(1);
        col_d = CNT_W'(rd_data) + CNT_W'(1);
      end else if (!unsafe) begin
        row_d = row_q + CNT_W'(1);
        col_d = '0;
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end else if (cmd_i.out_row) begin
      out_idx_d = out_idx_q + IDX_W'(1);
      if (cmd_i.resume) begin
        row_d = n - CNT_W'(1);
        col_d = CNT_W'(rd_data) + CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = cmd_i.out_row || cmd_i.out_none;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_size_q <= nqbe_pkg::BOARD_SIZE_RESET;
      row_q        <= '0;
      col_q        <= '0;
      exh_q        <= 1'b0;
      out_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      board_size_q <= board_size_d;
      row_q        <= row_d;
      col_q        <= col_d;
      exh_q        <= exh_d;
      out_idx_q    <= out_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (place) begin
      placed_q[row_q[IDX_W-1:0]] <= col_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && cmd_i.out_row) begin
      found_q     <= 1'b1;
      row_index_q <= nqbe_pkg::ROW_INDEX_W'(out_idx_q);
      column_q    <= nqbe_pkg::COLUMN_W'(rd_data);
      last_q      <= out_last;
    end else if (out_free && cmd_i.out_none) begin
      found_q     <= 1'b0;
      row_index_q <= '0;
      column_q    <= '0;
      last_q      <= 1'b1;
    end
  end

  assign board_size_o = board_size_q;
  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign row_index_o  = row_index_q;
  assign column_o     = column_q;
  assign last_o       = last_q;

endmodule
